FILE: rtl/core/linear_gap_interpolator_macros.svh
`ifndef LINEAR_GAP_INTERPOLATOR_MACROS_SVH
`define LINEAR_GAP_INTERPOLATOR_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define LGI_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define LGI_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/lgi_pkg.sv
`default_nettype none

package lgi_pkg;

   localparam int SAMPLE_W  = 32;
   localparam int DIFF_W    = SAMPLE_W + 1;
   localparam int DIV_ITERS = SAMPLE_W;
   localparam int ITER_W    = $clog2(DIV_ITERS);

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [DIFF_W-1:0]   diff_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV,
      ST_EMIT
   } lgi_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

`default_nettype wire

FILE: rtl/core/lgi_if.sv
`default_nettype none

interface lgi_req_if;
   logic                 valid;
   logic                 ready;
   lgi_pkg::sample_type  sample;
   logic                 is_missing;
   logic                 series_end;

   modport source (output valid, output sample, output is_missing, output series_end,
                   input ready);
   modport sink   (input valid, input sample, input is_missing, input series_end,
                   output ready);
endinterface

interface lgi_rsp_if;
   logic                 valid;
   logic                 ready;
   lgi_pkg::sample_type  value;
   logic                 was_filled;
   logic                 run_last;
   logic                 series_last;

   modport source (output valid, output value, output was_filled, output run_last,
                   output series_last, input ready);
   modport sink   (input valid, input value, input was_filled, input run_last,
                   input series_last, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/lgi_div.sv
`default_nettype none

module lgi_div #(
   parameter int DIV_W = 7
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire lgi_pkg::diff_type      dividend,
   input  wire logic [DIV_W-1:0]       divisor,
   output lgi_pkg::div_stat_type       stat,
   output lgi_pkg::diff_type           quotient
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic                          neg_ff, neg_in;
   logic [lgi_pkg::SAMPLE_W-1:0]  dvd_ff, dvd_in;
   logic [DIV_W-1:0]              rem_ff, rem_in;
   logic [DIV_W-1:0]              dsr_ff, dsr_in;
   logic [lgi_pkg::ITER_W-1:0]    cnt_ff, cnt_in;

   lgi_pkg::diff_type             mag;
   logic [DIV_W+1:0]              shifted;
   logic [DIV_W+1:0]              trial;
   logic                          fits;

   assign mag     = dividend[lgi_pkg::DIFF_W-1] ? -dividend : dividend;
   assign shifted = {1'b0, rem_ff, dvd_ff[lgi_pkg::SAMPLE_W-1]};
   assign trial   = shifted - {2'b00, dsr_ff};
   assign fits    = !trial[DIV_W+1];

   // Restoring divide on magnitudes, one quotient bit per cycle.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         neg_in  = dividend[lgi_pkg::DIFF_W-1];
         dvd_in  = mag[lgi_pkg::SAMPLE_W-1:0];
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? trial[DIV_W-1:0] : shifted[DIV_W-1:0];
         dvd_in = {dvd_ff[lgi_pkg::SAMPLE_W-2:0], fits};
         cnt_in = cnt_ff + lgi_pkg::ITER_W'(1);
         if (cnt_ff == lgi_pkg::ITER_W'(lgi_pkg::DIV_ITERS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      neg_ff <= neg_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = neg_ff ? -lgi_pkg::diff_type'({1'b0, dvd_ff})
                             : lgi_pkg::diff_type'({1'b0, dvd_ff});

endmodule

`default_nettype wire

FILE: rtl/core/linear_gap_interpolator.sv
// Missing samples are absorbed and give no beat, unless one ends the series or finds the gap full.
// Other items go through the emit state into the output register, one beat per cycle when rsp is ready.
// An interior gap with a left neighbour first passes the prep and divide states for the serial 32-step divide.
// The block takes no new item until the last beat of the current one is loaded into the output register.
// Synchronous active-high reset drops pending beats and starts a fresh series.
`default_nettype none

module linear_gap_interpolator #(
   parameter int MAX_GAP = 63
) (
   input  wire logic  clock,
   input  wire logic  reset,
   lgi_req_if.sink    req,
   lgi_rsp_if.source  rsp
);

   `include "linear_gap_interpolator_macros.svh"

   localparam int GAP_W = $clog2(MAX_GAP + 1);
   localparam int CNT_W = GAP_W + 1;

   lgi_pkg::lgi_state_type  state_ff, state_in;

   lgi_pkg::sample_type     prev_ff, prev_in;
   logic                    have_ff, have_in;
   logic [GAP_W-1:0]        gap_ff, gap_in;

   lgi_pkg::sample_type     acc_ff, acc_in;
   lgi_pkg::diff_type       step_ff, step_in;
   lgi_pkg::diff_type       diff_ff, diff_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    orig_ff, orig_in;
   lgi_pkg::sample_type     orig_val_ff, orig_val_in;
   logic                    end_ff, end_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   lgi_pkg::sample_type     rsp_value_ff, rsp_value_in;
   logic                    rsp_filled_ff, rsp_filled_in;
   logic                    rsp_run_ff, rsp_run_in;
   logic                    rsp_series_ff, rsp_series_in;

   logic                    accept;
   logic                    extend_only;
   logic                    need_div;
   logic                    div_start;
   logic                    emit_en;
   logic                    last_beat;
   lgi_pkg::sample_type     held;
   lgi_pkg::diff_type       fill_sum;
   lgi_pkg::div_stat_type   div_stat;
   lgi_pkg::diff_type       quotient;

   assign accept      = req.valid && req.ready;
   assign held        = have_ff ? prev_ff : '0;
   assign extend_only = req.is_missing && !req.series_end && (gap_ff < GAP_W'(MAX_GAP));
   assign need_div    = !req.is_missing && (gap_ff != '0) && have_ff;
   assign last_beat   = (cnt_ff == CNT_W'(1) && !orig_ff) || (cnt_ff == '0);
   assign fill_sum    = lgi_pkg::diff_type'(acc_ff) + step_ff;

   lgi_div #(
      .DIV_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (diff_ff),
      .divisor  (cnt_ff + CNT_W'(1)),
      .stat     (div_stat),
      .quotient (quotient)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lgi_pkg::ST_IDLE: begin
            if (accept && !extend_only) begin
               state_in = need_div ? lgi_pkg::ST_PREP : lgi_pkg::ST_EMIT;
            end
         end
         lgi_pkg::ST_PREP: state_in = lgi_pkg::ST_DIV;
         lgi_pkg::ST_DIV: begin
            if (div_stat.done) begin
               state_in = lgi_pkg::ST_EMIT;
            end
         end
         lgi_pkg::ST_EMIT: begin
            if (emit_en && last_beat) begin
               state_in = lgi_pkg::ST_IDLE;
            end
         end
         default: state_in = lgi_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req.ready = 1'b0;
      div_start = 1'b0;
      emit_en   = 1'b0;
      unique case (state_ff)
         lgi_pkg::ST_IDLE: req.ready = 1'b1;
         lgi_pkg::ST_PREP: div_start = 1'b1;
         lgi_pkg::ST_DIV:  ;
         lgi_pkg::ST_EMIT: emit_en = !rsp_valid_ff || rsp.ready;
         default:          ;
      endcase
   end

   // Series state and per-item work registers.
   always_comb begin
      prev_in     = prev_ff;
      have_in     = have_ff;
      gap_in      = gap_ff;
      acc_in      = acc_ff;
      step_in     = step_ff;
      diff_in     = diff_ff;
      cnt_in      = cnt_ff;
      orig_in     = orig_ff;
      orig_val_in = orig_val_ff;
      end_in      = end_ff;

      if (accept) begin
         step_in     = '0;
         orig_val_in = req.sample;
         end_in      = req.series_end;
         diff_in     = lgi_pkg::diff_type'(req.sample) - lgi_pkg::diff_type'(held);
         if (req.is_missing) begin
            acc_in  = held;
            orig_in = 1'b0;
            if (req.series_end) begin
               cnt_in  = CNT_W'(gap_ff) + CNT_W'(1);
               prev_in = '0;
               have_in = 1'b0;
               gap_in  = '0;
            end else if (gap_ff >= GAP_W'(MAX_GAP)) begin
               cnt_in = CNT_W'(gap_ff);
               gap_in = GAP_W'(1);
            end else begin
               gap_in = gap_ff + GAP_W'(1);
            end
         end else begin
            // Leading gap copies the new sample; otherwise ramp from the held value toward it.
            acc_in  = have_ff ? held : req.sample;
            cnt_in  = CNT_W'(gap_ff);
            orig_in = 1'b1;
            gap_in  = '0;
            if (req.series_end) begin
               prev_in = '0;
               have_in = 1'b0;
            end else begin
               prev_in = req.sample;
               have_in = 1'b1;
            end
         end
      end

      if (div_stat.done) begin
         step_in = quotient;
      end

      if (emit_en) begin
         if (cnt_ff != '0) begin
            cnt_in = cnt_ff - CNT_W'(1);
            acc_in = fill_sum[lgi_pkg::SAMPLE_W-1:0];
         end else begin
            orig_in = 1'b0;
         end
      end
   end

   // Output register: load a beat when the slot is free, drop it when taken.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_filled_in = rsp_filled_ff;
      rsp_run_in    = rsp_run_ff;
      rsp_series_in = rsp_series_ff;
      if (emit_en) begin
         rsp_valid_in  = 1'b1;
         rsp_run_in    = last_beat;
         rsp_series_in = last_beat && end_ff;
         if (cnt_ff != '0) begin
            rsp_value_in  = fill_sum[lgi_pkg::SAMPLE_W-1:0];
            rsp_filled_in = 1'b1;
         end else begin
            rsp_value_in  = orig_val_ff;
            rsp_filled_in = 1'b0;
         end
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lgi_pkg::ST_IDLE;
         prev_ff      <= '0;
         have_ff      <= 1'b0;
         gap_ff       <= '0;
         cnt_ff       <= '0;
         orig_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_ff      <= prev_in;
         have_ff      <= have_in;
         gap_ff       <= gap_in;
         cnt_ff       <= cnt_in;
         orig_ff      <= orig_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      acc_ff        <= acc_in;
      step_ff       <= step_in;
      diff_ff       <= diff_in;
      orig_val_ff   <= orig_val_in;
      end_ff        <= end_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_filled_ff <= rsp_filled_in;
      rsp_run_ff    <= rsp_run_in;
      rsp_series_ff <= rsp_series_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.value       = rsp_value_ff;
   assign rsp.was_filled  = rsp_filled_ff;
   assign rsp.run_last    = rsp_run_ff;
   assign rsp.series_last = rsp_series_ff;

   `LGI_ASSERT_NOW(a_orig_closes_run, rsp_valid_ff && !rsp_filled_ff, rsp_run_ff,
      "original sample beat must close its run")
   `LGI_ASSERT_NOW(a_series_in_run, rsp_valid_ff && rsp_series_ff, rsp_run_ff,
      "series_last without run_last")
   `LGI_ASSERT_NOW(a_div_done_in_div, div_stat.done, state_ff == lgi_pkg::ST_DIV,
      "divider finished outside the divide state")
   `LGI_ASSERT_NOW(a_div_busy_in_div, div_stat.busy, state_ff == lgi_pkg::ST_DIV,
      "divider running outside the divide state")
   `LGI_ASSERT_NOW(a_emit_has_beat, state_ff == lgi_pkg::ST_EMIT, cnt_ff != '0 || orig_ff,
      "emit state with nothing to send")

endmodule

`default_nettype wire

FILE: dv/linear_gap_interpolator_test.sv
`timescale 1ns / 1ps

module linear_gap_interpolator_test;

   localparam int                  GAP_LIMIT        = 63;
   localparam int                  RANDOM_ITEMS     = 40;
   localparam int                  RSP_STALL_CYCLES = 300;
   localparam int                  DRAIN_CYCLES     = 40;
   localparam int                  WATCHDOG_CYCLES  = 3000;
   localparam int                  REPORT_LIMIT     = 100;
   localparam lgi_pkg::sample_type SAMPLE_MAX       = 32'sh7FFF_FFFF;
   localparam lgi_pkg::sample_type SAMPLE_MIN       = 32'sh8000_0000;

   typedef struct {
      lgi_pkg::sample_type value;
      logic                was_filled;
      logic                run_last;
      logic                series_last;
   } out_sample_type;

   logic clock;
   logic reset;

   lgi_req_if req_bus ();
   lgi_rsp_if rsp_bus ();

   linear_gap_interpolator #(.MAX_GAP(GAP_LIMIT)) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   // filled and original samples the block owes, oldest first
   out_sample_type series_out_q[$];

   // line state mirrored from the block
   lgi_pkg::sample_type last_valid;
   bit                  seen_valid;
   int                  pending_gap;

   int mismatch_count   = 0;
   bit sender_idle_on   = 1'b1;
   bit receiver_idle_on = 1'b1;
   bit rsp_stall_request = 1'b0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic void push_sample(lgi_pkg::sample_type v, logic filled);
      out_sample_type b;
      b.value       = v;
      b.was_filled  = filled;
      b.run_last    = 1'b0;
      b.series_last = 1'b0;
      series_out_q.push_back(b);
   endfunction

   function automatic void close_run(logic ends_series);
      out_sample_type b;
      b = series_out_q.pop_back();
      b.run_last    = 1'b1;
      b.series_last = ends_series;
      series_out_q.push_back(b);
   endfunction

   function automatic void clear_line();
      last_valid  = '0;
      seen_valid  = 1'b0;
      pending_gap = 0;
   endfunction

   function automatic void interpolate_item(lgi_pkg::sample_type s, logic missing, logic last);
      lgi_pkg::sample_type held;
      longint              step;
      longint              point;
      held = seen_valid ? last_valid : '0;
      if (missing) begin
         if (last) begin
            // trailing gap: hold the left neighbor, this sample included
            for (int i = 0; i <= pending_gap; i++) push_sample(held, 1'b1);
            close_run(1'b1);
            clear_line();
         end else if (pending_gap >= GAP_LIMIT) begin
            // overlong gap: flush as held values, restart with this one
            for (int i = 0; i < pending_gap; i++) push_sample(held, 1'b1);
            close_run(1'b0);
            pending_gap = 1;
         end else begin
            pending_gap++;
         end
      end else begin
         if (pending_gap > 0) begin
            if (seen_valid) begin
               step = (longint'(s) - longint'(held)) / longint'(pending_gap + 1);
               for (int i = 1; i <= pending_gap; i++) begin
                  point = longint'(held) + step * i;
                  push_sample(point[lgi_pkg::SAMPLE_W-1:0], 1'b1);
               end
            end else begin
               for (int i = 0; i < pending_gap; i++) push_sample(s, 1'b1);
            end
         end
         push_sample(s, 1'b0);
         close_run(last);
         if (last) begin
            clear_line();
         end else begin
            last_valid  = s;
            seen_valid  = 1'b1;
            pending_gap = 0;
         end
      end
   endfunction

   function automatic lgi_pkg::sample_type pick_sample();
      case ($urandom_range(0, 9))
         0:       return SAMPLE_MAX;
         1:       return SAMPLE_MIN;
         2:       return '0;
         3, 4, 5: return lgi_pkg::sample_type'(int'($urandom_range(0, 2000)) - 1000);
         default: return lgi_pkg::sample_type'($urandom);
      endcase
   endfunction

   task automatic report_field(string field, logic [lgi_pkg::SAMPLE_W-1:0] want,
                               logic [lgi_pkg::SAMPLE_W-1:0] got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
   endtask

   // entered at a falling edge, returns at the falling edge after the beat is taken
   task automatic send_item(lgi_pkg::sample_type s, logic missing, logic last);
      if (sender_idle_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.sample     <= s;
      req_bus.is_missing <= missing;
      req_bus.series_end <= last;
      do @(posedge clock); while (!req_bus.ready);
      interpolate_item(s, missing, last);
      @(negedge clock);
   endtask

   task automatic send_gap(int count);
      for (int i = 0; i < count; i++)
         send_item(lgi_pkg::sample_type'($urandom), 1'b1, 1'b0);
   endtask

   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      while (series_out_q.size() != 0) @(negedge clock);
      // a trailing absorb or divide may still be in flight
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic test_directed_cases();
      // interior gaps across the full range, then a short trailing hold
      send_item(SAMPLE_MAX, 1'b0, 1'b0);
      send_gap(2);
      send_item(SAMPLE_MIN, 1'b0, 1'b0);
      send_gap(1);
      send_item('0, 1'b0, 1'b0);
      send_item(lgi_pkg::sample_type'($urandom), 1'b1, 1'b1);
      // leading gap copies the first valid sample
      send_gap(2);
      send_item(32'sh1234_5678, 1'b0, 1'b0);
      send_item(-32'sd1, 1'b0, 1'b1);
      // all missing gives zeros, sample bits ignored
      send_item(-32'sd1, 1'b1, 1'b0);
      send_item(SAMPLE_MAX, 1'b1, 1'b0);
      send_item(SAMPLE_MIN, 1'b1, 1'b1);
      send_item(SAMPLE_MIN, 1'b0, 1'b1);
      send_item('0, 1'b1, 1'b1);
      // small steps truncate toward zero on both signs
      send_item(-32'sd1, 1'b0, 1'b0);
      send_gap(3);
      send_item(32'sd1, 1'b0, 1'b0);
      send_gap(2);
      send_item(-32'sd6, 1'b0, 1'b1);
   endtask

   task automatic test_long_gaps();
      send_item(32'sd100, 1'b0, 1'b0);
      send_gap(GAP_LIMIT);
      send_item(-32'sd100, 1'b0, 1'b0);
      send_gap(GAP_LIMIT + 1);
      send_item(32'sd9, 1'b0, 1'b1);
      send_gap(GAP_LIMIT + 1);
      send_item(32'sd3, 1'b0, 1'b1);
      send_item(-32'sd50, 1'b0, 1'b0);
      send_gap(GAP_LIMIT);
      send_item(SAMPLE_MAX, 1'b1, 1'b1);
   endtask

   task automatic test_output_backpressure();
      rsp_stall_request = 1'b1;
      for (int i = 0; i < 40; i++)
         send_item(pick_sample(), $urandom_range(0, 2) == 0, (i % 10) == 9);
   endtask

   task automatic test_drain_pause();
      send_item(pick_sample(), 1'b0, 1'b0);
      send_gap(4);
      wait_for_drain();
      send_item(pick_sample(), 1'b0, 1'b0);
      send_gap(2);
      send_item(pick_sample(), 1'b1, 1'b1);
      wait_for_drain();
   endtask

   task automatic test_random_series();
      int   sent;
      int   len;
      int   miss_pct;
      logic missing;
      logic last;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if (sent >= RANDOM_ITEMS - 20) begin
            sender_idle_on   = 1'b0;
            receiver_idle_on = 1'b0;
         end else if ($urandom_range(0, 4) == 0) begin
            sender_idle_on   = $urandom_range(0, 1);
            receiver_idle_on = $urandom_range(0, 1);
         end
         len = $urandom_range(1, 24);
         case ($urandom_range(0, 9))
            0:       miss_pct = 0;
            1:       miss_pct = 100;
            2, 3:    miss_pct = 70;
            default: miss_pct = 30;
         endcase
         for (int k = 0; k < len; k++) begin
            missing = $urandom_range(1, 100) <= miss_pct;
            last    = (k == len - 1);
            // break a series early now and then
            if ($urandom_range(0, 19) == 0) last = $urandom_range(0, 1);
            send_item(missing ? lgi_pkg::sample_type'($urandom) : pick_sample(), missing, last);
            sent++;
         end
      end
   endtask

   // receiver: random stall bursts, plus one long hold when asked
   initial begin
      int stall_left;
      int burst_left;
      stall_left    = 0;
      burst_left    = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_stall_request) begin
            stall_left        = RSP_STALL_CYCLES;
            rsp_stall_request = 1'b0;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (burst_left > 0) begin
            burst_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (receiver_idle_on && $urandom_range(0, 4) == 0)
               burst_left = $urandom_range(1, 7);
         end
      end
   end

   always @(posedge clock) begin
      out_sample_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (series_out_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("%0t: beat with nothing pending, expected none, actual value %h",
                        $time, rsp_bus.value);
         end else begin
            want = series_out_q.pop_front();
            if (rsp_bus.value !== want.value)
               report_field("value", want.value, rsp_bus.value);
            if (rsp_bus.was_filled !== want.was_filled)
               report_field("was_filled", want.was_filled, rsp_bus.was_filled);
            if (rsp_bus.run_last !== want.run_last)
               report_field("run_last", want.run_last, rsp_bus.run_last);
            if (rsp_bus.series_last !== want.series_last)
               report_field("series_last", want.series_last, rsp_bus.series_last);
         end
      end
   end

   // watchdog: end the run when no beat moves on either side for too long
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_CYCLES) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("FAIL linear_gap_interpolator");
      $finish;
   end

   initial begin
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.sample     = '0;
      req_bus.is_missing = 1'b0;
      req_bus.series_end = 1'b0;
      clear_line();
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_cases();
      test_long_gaps();
      test_output_backpressure();
      test_drain_pause();
      test_random_series();
      wait_for_drain();

      if (mismatch_count == 0)
         $display("PASS linear_gap_interpolator");
      else
         $display("FAIL linear_gap_interpolator");
      $finish;
   end

endmodule
